// ===== hw/rtl/card_id_base64_rle_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the card ID decoder.
// Shared property forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CARD_ID_BASE64_RLE_DECODER_TOP_MACROS_SVH
`define CARD_ID_BASE64_RLE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CIDRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CIDRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cidrle_pkg.sv =====
// ----------------------------------------------------------------------------
// Card ID decoder package
// Types, codes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cidrle_pkg;

	localparam int CARD_ID_W   = 18;
	localparam int REPEAT_W    = 7;
	localparam int DIGIT_W     = 6;
	localparam int PARTIAL_W   = 12;
	localparam int SHORT_ID_W  = 15;

	localparam logic [PARTIAL_W-1:0]  PAIR_REPEAT_BASE = 12'd4001;
	localparam logic [SHORT_ID_W-1:0] PREFIX_STEP      = 15'd4000;

	localparam logic MODE_PAIR   = 1'b0;
	localparam logic MODE_TRIPLE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_CHAR = 2'd1,
		STATUS_BAD_LEN  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_ONE   = 4'b0010,
		PH_TWO   = 4'b0100,
		PH_HALT  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_string;
	} char_item_t;

	typedef struct packed {
		logic [CARD_ID_W-1:0] card_id;
		logic [REPEAT_W-1:0]  repeat_count;
		logic                 has_card;
		status_t              status;
		logic                 end_of_hash;
	} card_item_t;

	typedef struct packed {
		logic [DIGIT_W-1:0]    digit;
		logic                  digit_ok;
		logic                  prefix_ok;
		logic [SHORT_ID_W-1:0] prefix_offset;
	} char_dec_t;

	typedef struct packed {
		phase_t                phase;
		logic [PARTIAL_W-1:0]  partial;
		logic [SHORT_ID_W-1:0] id_offset;
		logic [SHORT_ID_W-1:0] previous_id;
		logic                  error;
	} str_state_t;

	localparam str_state_t STR_STATE_RESET = '{
		phase:       PH_START,
		partial:     '0,
		id_offset:   '0,
		previous_id: '0,
		error:       1'b0
	};

endpackage

`default_nettype wire

// ===== hw/rtl/cidrle_char_dec.sv =====
// ----------------------------------------------------------------------------
// Character classifier
// Maps one character to its base64 digit value and prefix offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cidrle_char_dec (
	input  wire logic [7:0]          char_code,
	output cidrle_pkg::char_dec_t    dec
);
	import cidrle_pkg::*;

	logic [7:0] off_upper;
	logic [7:0] off_lower;
	logic [7:0] off_num;

	assign off_upper = char_code - 8'd65;
	assign off_lower = char_code - 8'd71;
	assign off_num   = char_code + 8'd4;

	always_comb begin
		dec.digit         = '0;
		dec.digit_ok      = 1'b1;
		dec.prefix_ok     = 1'b1;
		dec.prefix_offset = '0;
		priority if (char_code >= "A" && char_code <= "Z") begin
			dec.digit = off_upper[DIGIT_W-1:0];
		end else if (char_code >= "a" && char_code <= "z") begin
			dec.digit = off_lower[DIGIT_W-1:0];
		end else if (char_code >= "0" && char_code <= "9") begin
			dec.digit = off_num[DIGIT_W-1:0];
		end else if (char_code == "+") begin
			dec.digit = 6'd62;
		end else if (char_code == "/") begin
			dec.digit = 6'd63;
		end else begin
			dec.digit_ok = 1'b0;
		end
		unique case (char_code)
			"-": dec.prefix_offset = PREFIX_STEP;
			".": dec.prefix_offset = 15'(PREFIX_STEP * 2);
			"~": dec.prefix_offset = 15'(PREFIX_STEP * 3);
			"!": dec.prefix_offset = 15'(PREFIX_STEP * 4);
			"*": dec.prefix_offset = 15'(PREFIX_STEP * 5);
			default: dec.prefix_ok = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cidrle_step.sv =====
// ----------------------------------------------------------------------------
// Token step logic
// Advances the per-string token state by one character and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cidrle_step (
	input  wire logic                   mode,
	input  wire logic                   end_of_string,
	input  wire cidrle_pkg::char_dec_t  dec,
	input  wire cidrle_pkg::str_state_t st,
	output cidrle_pkg::str_state_t      nxt,
	output cidrle_pkg::card_item_t      res,
	output logic                        emit
);
	import cidrle_pkg::*;

	logic                  err_new;
	logic [PARTIAL_W-1:0]  pair;
	logic                  pair_is_id;
	logic [SHORT_ID_W-1:0] id_sum;
	logic [PARTIAL_W-1:0]  repeat_left;
	logic                  have;
	logic [CARD_ID_W-1:0]  card;
	logic [REPEAT_W-1:0]   count;
	status_t               status;

	assign err_new     = st.error | ~dec.digit_ok;
	assign pair        = {st.partial[DIGIT_W-1:0], dec.digit};
	assign pair_is_id  = pair < PAIR_REPEAT_BASE;
	assign id_sum      = {3'b000, pair} + st.id_offset;
	assign repeat_left = pair - PAIR_REPEAT_BASE;

	always_comb begin
		nxt    = st;
		have   = 1'b0;
		card   = '0;
		count  = '0;
		status = STATUS_OK;
		unique case (st.phase)
			PH_START: begin
				if (mode == MODE_PAIR && dec.prefix_ok) begin
					nxt.id_offset = dec.prefix_offset;
					nxt.phase     = PH_ONE;
				end else begin
					nxt.error   = err_new;
					nxt.partial = {6'd0, dec.digit};
					nxt.phase   = (mode == MODE_PAIR) ? PH_TWO : PH_ONE;
				end
			end
			PH_ONE: begin
				nxt.error = err_new;
				nxt.phase = PH_TWO;
				if (mode == MODE_PAIR) begin
					nxt.partial = {6'd0, dec.digit};
				end else begin
					nxt.partial = pair;
				end
			end
			PH_TWO: begin
				nxt.error = err_new;
				if (err_new) begin
					nxt.phase = PH_HALT;
				end else begin
					have          = 1'b1;
					nxt.phase     = PH_START;
					nxt.partial   = '0;
					nxt.id_offset = '0;
					if (mode == MODE_TRIPLE) begin
						card  = {st.partial, dec.digit};
						count = 7'd1;
					end else if (pair_is_id) begin
						card            = {3'b000, id_sum};
						nxt.previous_id = id_sum;
						count           = 7'd1;
					end else begin
						card  = {3'b000, st.previous_id};
						count = repeat_left[REPEAT_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase

		if (end_of_string) begin
			priority if (nxt.phase == PH_ONE || nxt.phase == PH_TWO) begin
				status = STATUS_BAD_LEN;
			end else if (nxt.error) begin
				status = STATUS_BAD_CHAR;
			end else begin
				status = STATUS_OK;
			end
			nxt = STR_STATE_RESET;
		end
	end

	assign res.card_id      = card;
	assign res.repeat_count = count;
	assign res.has_card     = have;
	assign res.status       = status;
	assign res.end_of_hash  = end_of_string;
	assign emit             = have | end_of_string;

endmodule

`default_nettype wire

// ===== hw/rtl/card_id_base64_rle_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Card ID base64 run-length decoder
// Decodes an encoded ID string, one character per word, into card IDs.
//
//   Channel  Direction  Word
//   char     in         char_item_t: character and end-of-string flag
//   card     out        card_item_t: ID, repeat count, status, end flag
//   cfg      in         encoding mode bit, always ready
//
// One character word is taken per cycle while the card channel is not stalled;
// a result is formed from the input register and held in the result register.
// Reset clears the token state and the mode; no clearing pass is needed.
// A stalled card channel holds the result and stops the input register,
// while one more character may still enter the input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "card_id_base64_rle_decoder_top_macros.svh"

module card_id_base64_rle_decoder_top (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    char_valid,
	output logic                         char_ready,
	input  wire cidrle_pkg::char_item_t  char_data,
	output logic                         card_valid,
	input  wire logic                    card_ready,
	output cidrle_pkg::card_item_t       card_data,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic                    cfg_data
);
	import cidrle_pkg::*;

	logic       mode_q;
	logic       char_valid_s1;
	char_item_t char_s1;
	str_state_t st_q;
	str_state_t st_nxt;
	char_dec_t  dec;
	card_item_t res;
	logic       emit;
	logic       advance;
	logic       card_valid_q;
	card_item_t card_q;

	assign cfg_ready  = 1'b1;
	assign advance    = char_valid_s1 & (~card_valid_q | card_ready);
	assign char_ready = ~char_valid_s1 | advance;
	assign card_valid = card_valid_q;
	assign card_data  = card_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PAIR;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_s1 <= 1'b0;
		end else if (char_ready) begin
			char_valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			char_s1 <= char_data;
		end
	end

	cidrle_char_dec u_char_dec (
		.char_code (char_s1.char_code),
		.dec       (dec)
	);

	cidrle_step u_step (
		.mode          (mode_q),
		.end_of_string (char_s1.end_of_string),
		.dec           (dec),
		.st            (st_q),
		.nxt           (st_nxt),
		.res           (res),
		.emit          (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STR_STATE_RESET;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_valid_q <= 1'b0;
		end else if (advance) begin
			card_valid_q <= emit;
		end else if (card_ready) begin
			card_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			card_q <= res;
		end
	end

	`CIDRLE_ASSERT_NOW(a_cardless_is_final, clk, arst_n,
		card_valid_q && !card_q.has_card, card_q.end_of_hash, "cardless result not final")
	`CIDRLE_ASSERT_NOW(a_cardless_is_zero, clk, arst_n,
		card_valid_q && !card_q.has_card,
		card_q.card_id == '0 && card_q.repeat_count == '0, "cardless result not zero")
	`CIDRLE_ASSERT_NOW(a_halt_has_error, clk, arst_n,
		st_q.phase == PH_HALT, st_q.error, "halted without a latched error")
	`CIDRLE_ASSERT_NEXT(a_end_clears_state, clk, arst_n,
		advance && char_s1.end_of_string,
		st_q.phase == PH_START && !st_q.error && st_q.previous_id == '0,
		"string state not cleared at end of string")

endmodule

`default_nettype wire
